// ===== src/ecisr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecisr_pkg
// Types, constants and elaboration-time functions shared by the Earth rotation
// transform: word layouts, register indexes and the CORDIC constant tables.
// ----------------------------------------------------------------------------
package ecisr_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int PHASE_BITS    = 32;

  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 1;
  localparam int TURNS_W   = 40;
  localparam int RADS_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_TURNS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_RADIANS = 1'b1;

  localparam logic [TURNS_W-1:0] RATE_TURNS_RST   = 40'd836280000000;
  localparam logic [RADS_W-1:0]  RATE_RADIANS_RST = 32'd80178000;

  localparam logic MODE_TRANSPORT = 1'b0;
  localparam logic MODE_ROTATE    = 1'b1;

  localparam int MUL_AW = 64;
  localparam int MUL_BW = 56;
  localparam int MUL_PW = 120;

  localparam logic [63:0] TWO_PI_Q61     = 64'hC90FDAA22168C235;
  localparam logic [63:0] TWO_PI_HALF    = TWO_PI_Q61 >> 1;
  localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;

  typedef struct packed {
    logic signed [47:0] time_s;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               mode;
  } in_word_t;

  typedef struct packed {
    logic signed [39:0] fixed_pos_x;
    logic signed [39:0] fixed_pos_y;
    logic signed [39:0] fixed_pos_z;
    logic signed [31:0] fixed_vel_x;
    logic signed [31:0] fixed_vel_y;
    logic signed [31:0] fixed_vel_z;
    logic signed [31:0] fixed_acc_x;
    logic signed [31:0] fixed_acc_y;
    logic signed [31:0] fixed_acc_z;
  } out_word_t;

  function automatic logic [63:0] const_udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [63:0] atan_q60(int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI_Q60;
    end
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = const_udiv(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + 64'sd2) >>> 2;
  endfunction

  function automatic logic signed [63:0] gain_q61();
    logic [63:0]  v;
    logic [63:0]  s;
    logic [63:0]  t;
    logic [127:0] target;
    v = 64'd1 << 62;
    s = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 63) begin
        v = v - const_udiv(v, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    target = {64'd0, v} << 62;
    for (int b = 62; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= target) begin
        s = t;
      end
    end
    return (s + 64'd1) >> 1;
  endfunction

endpackage

// ===== src/ecisr_mul.sv =====
// ----------------------------------------------------------------------------
// ecisr_mul
// Two-stage signed 64 x 56 multiplier: four registered partial products,
// then one registered final sum.
// ----------------------------------------------------------------------------
module ecisr_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [ecisr_pkg::MUL_AW-1:0]  a_i,
  input  logic signed [ecisr_pkg::MUL_BW-1:0]  b_i,
  output logic signed [ecisr_pkg::MUL_PW-1:0]  p_o
);
  import ecisr_pkg::*;

  logic signed [32:0] al;
  logic signed [31:0] ah;
  logic signed [28:0] bl;
  logic signed [27:0] bh;
  logic signed [61:0] ll_q;
  logic signed [60:0] lh_q;
  logic signed [60:0] hl_q;
  logic signed [59:0] hh_q;
  logic signed [MUL_PW-1:0] p_d;
  logic signed [MUL_PW-1:0] p_q;

  assign al = {1'b0, a_i[31:0]};
  assign ah = a_i[63:32];
  assign bl = {1'b0, b_i[27:0]};
  assign bh = b_i[55:28];

  assign p_d = (MUL_PW'(hh_q) <<< 60) + (MUL_PW'(hl_q) <<< 32)
             + (MUL_PW'(lh_q) <<< 28) + MUL_PW'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= al * bl;
      lh_q <= al * bh;
      hl_q <= ah * bl;
      hh_q <= ah * bh;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/ecisr_cordic.sv =====
// ----------------------------------------------------------------------------
// ecisr_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage, giving the
// cosine and sine of an angle in Q61 from an angle in Q60.
// ----------------------------------------------------------------------------
module ecisr_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o
);
  import ecisr_pkg::*;

  localparam logic signed [63:0] GAIN = gain_q61();

  logic signed [63:0] x_q [CORDIC_STAGES];
  logic signed [63:0] y_q [CORDIC_STAGES];
  logic signed [63:0] z_q [CORDIC_STAGES-1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [63:0] DA = atan_q60(i);
    logic signed [63:0] xp;
    logic signed [63:0] yp;
    logic signed [63:0] zp;

    if (i == 0) begin : g_first
      assign xp = GAIN;
      assign yp = '0;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zp[63]) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
        end
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_angle
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= zp[63] ? zp + DA : zp - DA;
        end
      end
    end
  end

  assign x_o = x_q[CORDIC_STAGES-1];
  assign y_o = y_q[CORDIC_STAGES-1];

endmodule

// ===== src/eci_to_ecef_state_rotation.sv =====
// ----------------------------------------------------------------------------
// eci_to_ecef_state_rotation
// Rotates an inertial position, velocity and acceleration into the
// Earth-fixed frame, optionally adding the transport terms first.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Carries
//  in        input      in_valid_i / in_stall_o    in_word_t
//  out       output     out_valid_o / out_stall_i  out_word_t
//  cfg       input      cfg_we_i                   rate_turns, rate_radians
//
//  One word is taken every cycle while the pipeline is not held; the CORDIC
//  pipeline makes up most of the depth between an accepted word and its
//  result. The whole pipeline holds while a result waits on out_stall_i.
//  Reset empties the pipeline and loads the default rates.
// ----------------------------------------------------------------------------
module eci_to_ecef_state_rotation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ecisr_pkg::in_word_t                  in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ecisr_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [ecisr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ecisr_pkg::CFG_W-1:0]          cfg_data_i
);
  import ecisr_pkg::*;

  localparam int N    = CORDIC_STAGES;
  localparam int PB   = PHASE_BITS;
  localparam int LAST = N + 11;
  localparam int SD   = N + 8;
  localparam int QD   = N + 4;

  localparam logic [PB-1:0] PH_HALF = PB'(1) << (PB - 3);
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam logic signed [MUL_PW-1:0] HALF_POS = MUL_PW'(1) <<< 60;
  localparam logic signed [MUL_PW-1:0] HALF_VEL = MUL_PW'(1) <<< 76;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_z;
    logic signed [55:0] vt_x;
    logic signed [55:0] vt_y;
    logic signed [55:0] at_x;
    logic signed [55:0] at_y;
    logic               mode;
  } side_t;

  logic adv;
  logic [LAST:0] vld_q;
  logic [TURNS_W-1:0] rate_turns_q;
  logic [RADS_W-1:0]  rate_radians_q;

  in_word_t in_q, in1_q, in2_q;
  side_t side3_d, side5_d;
  side_t side_q [SD];
  logic [1:0] q3_d;
  logic [1:0] q_q [QD];
  logic signed [PB-3:0] r3_d;
  logic signed [PB-3:0] r_q [3];
  logic [PB-1:0] phase;
  logic [PB-1:0] pq;
  logic signed [63:0] z6_d, z6_q;
  logic signed [MUL_PW-1:0] zf;
  logic signed [63:0] cx, cy, c_d, s_d, c_q, s_q;

  logic signed [MUL_PW-1:0] p_phase, p_w2, p_pyw, p_pxw, p_vyw, p_vxw;
  logic signed [MUL_PW-1:0] p_pxw2l, p_pxw2h, p_pyw2l, p_pyw2h, p_z;
  logic signed [MUL_PW-1:0] wwx_f, wwy_f;
  logic signed [55:0] vx_sh, vy_sh, ax_sh, ay_sh, t_pyw, t_pxw, t_vyw, t_vxw, t_wwx, t_wwy;
  logic signed [MUL_AW-1:0] rot_a [12];
  logic signed [MUL_BW-1:0] rot_b [12];
  logic signed [MUL_PW-1:0] rot_p [12];
  logic signed [MUL_PW-1:0] sum_d [6];
  logic signed [MUL_PW-1:0] sum_q [6];
  out_word_t out_d, out_q;

  function automatic logic signed [39:0] sat_pos(logic signed [MUL_PW-1:0] v);
    logic signed [58:0] t;
    t = v[119:61];
    if (&t[58:39] || ~|t[58:39]) begin
      return t[39:0];
    end
    return t[58] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat_rate(logic signed [MUL_PW-1:0] v);
    logic signed [42:0] t;
    t = v[119:77];
    if (&t[42:31] || ~|t[42:31]) begin
      return t[31:0];
    end
    return t[42] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  assign adv        = ~(vld_q[LAST] & out_stall_i);
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      rate_turns_q   <= RATE_TURNS_RST;
      rate_radians_q <= RATE_RADIANS_RST;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAST-1:0], in_valid_i};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RATE_TURNS:   rate_turns_q   <= cfg_data_i[TURNS_W-1:0];
          REG_RATE_RADIANS: rate_radians_q <= cfg_data_i[RADS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  ecisr_mul u_m_phase (.clk_i, .en_i(adv), .a_i(MUL_AW'(in_q.time_s)),
                       .b_i({16'd0, rate_turns_q}), .p_o(p_phase));
  ecisr_mul u_m_w2    (.clk_i, .en_i(adv), .a_i({32'd0, rate_radians_q}),
                       .b_i({24'd0, rate_radians_q}), .p_o(p_w2));
  ecisr_mul u_m_pyw   (.clk_i, .en_i(adv), .a_i({32'd0, rate_radians_q}),
                       .b_i(MUL_BW'(in_q.pos_y)), .p_o(p_pyw));
  ecisr_mul u_m_pxw   (.clk_i, .en_i(adv), .a_i({32'd0, rate_radians_q}),
                       .b_i(MUL_BW'(in_q.pos_x)), .p_o(p_pxw));
  ecisr_mul u_m_vyw   (.clk_i, .en_i(adv), .a_i({32'd0, rate_radians_q}),
                       .b_i(MUL_BW'(in_q.vel_y)), .p_o(p_vyw));
  ecisr_mul u_m_vxw   (.clk_i, .en_i(adv), .a_i({32'd0, rate_radians_q}),
                       .b_i(MUL_BW'(in_q.vel_x)), .p_o(p_vxw));
  ecisr_mul u_m_pxw2l (.clk_i, .en_i(adv), .a_i({32'd0, p_w2[31:0]}),
                       .b_i(MUL_BW'(in2_q.pos_x)), .p_o(p_pxw2l));
  ecisr_mul u_m_pxw2h (.clk_i, .en_i(adv), .a_i({32'd0, p_w2[63:32]}),
                       .b_i(MUL_BW'(in2_q.pos_x)), .p_o(p_pxw2h));
  ecisr_mul u_m_pyw2l (.clk_i, .en_i(adv), .a_i({32'd0, p_w2[31:0]}),
                       .b_i(MUL_BW'(in2_q.pos_y)), .p_o(p_pyw2l));
  ecisr_mul u_m_pyw2h (.clk_i, .en_i(adv), .a_i({32'd0, p_w2[63:32]}),
                       .b_i(MUL_BW'(in2_q.pos_y)), .p_o(p_pyw2h));
  ecisr_mul u_m_z     (.clk_i, .en_i(adv), .a_i(TWO_PI_HALF),
                       .b_i(MUL_BW'(r_q[0])), .p_o(p_z));

  always_comb begin
    phase = p_phase[71:72-PB];
    pq    = phase + PH_HALF;
    q3_d  = pq[PB-1:PB-2];
    r3_d  = {~pq[PB-3], pq[PB-4:0]};

    vx_sh = {{8{in2_q.vel_x[31]}}, in2_q.vel_x, 16'd0};
    vy_sh = {{8{in2_q.vel_y[31]}}, in2_q.vel_y, 16'd0};
    ax_sh = {{8{in2_q.acc_x[31]}}, in2_q.acc_x, 16'd0};
    ay_sh = {{8{in2_q.acc_y[31]}}, in2_q.acc_y, 16'd0};
    t_pyw = '0;
    t_pxw = '0;
    t_vyw = '0;
    t_vxw = '0;
    if (in2_q.mode == MODE_TRANSPORT) begin
      t_pyw = p_pyw[75:20];
      t_pxw = p_pxw[75:20];
      t_vyw = p_vyw[74:19];
      t_vxw = p_vxw[74:19];
    end
    side3_d.pos_x = in2_q.pos_x;
    side3_d.pos_y = in2_q.pos_y;
    side3_d.pos_z = in2_q.pos_z;
    side3_d.vel_z = in2_q.vel_z;
    side3_d.acc_z = in2_q.acc_z;
    side3_d.vt_x  = vx_sh + t_pyw;
    side3_d.vt_y  = vy_sh - t_pxw;
    side3_d.at_x  = ax_sh + t_vyw;
    side3_d.at_y  = ay_sh - t_vxw;
    side3_d.mode  = in2_q.mode;

    wwx_f = {p_pxw2h[87:0], 32'd0} + p_pxw2l;
    wwy_f = {p_pyw2h[87:0], 32'd0} + p_pyw2l;
    t_wwx = '0;
    t_wwy = '0;
    if (side_q[1].mode == MODE_TRANSPORT) begin
      t_wwx = wwx_f[111:56];
      t_wwy = wwy_f[111:56];
    end
    side5_d      = side_q[1];
    side5_d.at_x = side_q[1].at_x + t_wwx;
    side5_d.at_y = side_q[1].at_y + t_wwy;

    zf   = {p_z[MUL_PW-2:0], 1'b0} + (TWO_PI_Q61[0] ? MUL_PW'(r_q[2]) : MUL_PW'(0));
    z6_d = zf[PB+64:PB+1];
  end

  ecisr_cordic u_cordic (.clk_i, .en_i(adv), .z_i(z6_q), .x_o(cx), .y_o(cy));

  always_comb begin
    case (q_q[QD-1])
      QUAD_0: begin
        c_d = cx;
        s_d = cy;
      end
      QUAD_1: begin
        c_d = -cy;
        s_d = cx;
      end
      QUAD_2: begin
        c_d = -cx;
        s_d = -cy;
      end
      QUAD_3: begin
        c_d = cy;
        s_d = -cx;
      end
      default: begin
        c_d = cx;
        s_d = cy;
      end
    endcase
  end

  always_comb begin
    rot_b[0]  = MUL_BW'(side_q[N+4].pos_x);
    rot_b[1]  = MUL_BW'(side_q[N+4].pos_y);
    rot_b[4]  = side_q[N+4].vt_x;
    rot_b[5]  = side_q[N+4].vt_y;
    rot_b[8]  = side_q[N+4].at_x;
    rot_b[9]  = side_q[N+4].at_y;
    for (int v = 0; v < 3; v++) begin
      rot_a[4*v]   = c_q;
      rot_a[4*v+1] = s_q;
      rot_a[4*v+2] = c_q;
      rot_a[4*v+3] = s_q;
      rot_b[4*v+2] = rot_b[4*v+1];
      rot_b[4*v+3] = rot_b[4*v];
    end
  end

  for (genvar g = 0; g < 12; g++) begin : g_rot
    ecisr_mul u_m_rot (.clk_i, .en_i(adv), .a_i(rot_a[g]), .b_i(rot_b[g]), .p_o(rot_p[g]));
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      sum_d[2*v]   = rot_p[4*v] + rot_p[4*v+1] + (v == 0 ? HALF_POS : HALF_VEL);
      sum_d[2*v+1] = rot_p[4*v+2] - rot_p[4*v+3] + (v == 0 ? HALF_POS : HALF_VEL);
    end
    out_d.fixed_pos_x = sat_pos(sum_q[0]);
    out_d.fixed_pos_y = sat_pos(sum_q[1]);
    out_d.fixed_pos_z = side_q[SD-1].pos_z;
    out_d.fixed_vel_x = sat_rate(sum_q[2]);
    out_d.fixed_vel_y = sat_rate(sum_q[3]);
    out_d.fixed_vel_z = side_q[SD-1].vel_z;
    out_d.fixed_acc_x = sat_rate(sum_q[4]);
    out_d.fixed_acc_y = sat_rate(sum_q[5]);
    out_d.fixed_acc_z = side_q[SD-1].acc_z;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q      <= in_word_i;
      in1_q     <= in_q;
      in2_q     <= in1_q;
      side_q[0] <= side3_d;
      side_q[1] <= side_q[0];
      side_q[2] <= side5_d;
      for (int k = 3; k < SD; k++) begin
        side_q[k] <= side_q[k-1];
      end
      q_q[0] <= q3_d;
      for (int k = 1; k < QD; k++) begin
        q_q[k] <= q_q[k-1];
      end
      r_q[0] <= r3_d;
      r_q[1] <= r_q[0];
      r_q[2] <= r_q[1];
      z6_q   <= z6_d;
      c_q    <= c_d;
      s_q    <= s_d;
      for (int k = 0; k < 6; k++) begin
        sum_q[k] <= sum_d[k];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[LAST];
  assign out_word_o  = out_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("Pipeline valid bits moved while the pipeline was held.");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST-1] && adv) |=> out_valid_o)
    else $error("A word in the last stage but one did not reach the output.");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[LAST-1]))
    else $error("An output word appeared without a word behind it.");

endmodule

// ===== tb/sv/eci_to_ecef_state_rotation_chk.sv =====
// ----------------------------------------------------------------------------
// eci_to_ecef_state_rotation_chk
// Watches the input, output and register ports of the Earth rotation
// transform, predicts every Earth-fixed word from the accepted inertial word
// and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module eci_to_ecef_state_rotation_chk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  ecisr_pkg::in_word_t             in_word_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  ecisr_pkg::out_word_t            out_word_i,
  input  logic                            cfg_we_i,
  input  logic [ecisr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ecisr_pkg::CFG_W-1:0]     cfg_data_i,
  output int                              errors_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ecisr_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic [TURNS_W-1:0] turns_rate;
  logic [RADS_W-1:0]  rads_rate;
  out_word_t          fixed_q[$];
  longint             cordic_gain;
  int                 errors = 0;

  assign errors_o  = errors;
  assign pending_o = fixed_q.size();

  function automatic longint arctan_step(int i);
    longint      sum;
    logic [63:0] term;
    int          e;
    sum = 0;
    if (i == 0) begin
      return QUARTER_PI_Q60;
    end
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum + 2) >>> 2;
  endfunction

  function automatic longint gain_start();
    logic [63:0]  v;
    logic [63:0]  root;
    logic [63:0]  t;
    logic [127:0] target;
    v = 64'd1 << 62;
    root = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 63) v = v - v / ((64'd1 << (2 * i)) + 64'd1);
    end
    target = {64'd0, v} << 62;
    for (int b = 62; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= target) root = t;
    end
    return longint'((root + 64'd1) >> 1);
  endfunction

  function automatic logic [63:0] round_clip(wide_t v, int sh, int width);
    wide_t top;
    top = (wide_t'(1) <<< (width - 1)) - 1;
    v = (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    if (v > top) v = top;
    else if (v < -top - 1) v = -top - 1;
    return v[63:0];
  endfunction

  function automatic out_word_t predict_fixed(in_word_t w);
    wide_t       prod;
    wide_t       wr;
    wide_t       wsq;
    logic [31:0] pq;
    logic [1:0]  quad;
    longint      resid, z, x, y, c, s, tmp, dx, dy;
    longint      vtx, vty, atx, aty;
    out_word_t   o;
    prod  = wide_t'(w.time_s) * wide_t'({1'b0, turns_rate});
    pq    = prod[71:40] + 32'h2000_0000;
    quad  = pq[31:30];
    resid = longint'({34'd0, pq[29:0]}) - 64'sd536870912;
    prod  = wide_t'(resid) * wide_t'({1'b0, TWO_PI_Q61});
    z     = longint'(prod >>> 33);
    x = cordic_gain;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_step(i);
      end
    end
    c = x;
    s = y;
    case (quad)
      2'd1: begin tmp = c; c = -s; s = tmp; end
      2'd2: begin c = -c; s = -s; end
      2'd3: begin tmp = c; c = s; s = -tmp; end
      default: ;
    endcase
    wr  = wide_t'({1'b0, rads_rate});
    wsq = wide_t'({1'b0, 64'({32'd0, rads_rate} * {32'd0, rads_rate})});
    vtx = longint'(w.vel_x) * 65536;
    vty = longint'(w.vel_y) * 65536;
    atx = longint'(w.acc_x) * 65536;
    aty = longint'(w.acc_y) * 65536;
    if (w.mode == MODE_TRANSPORT) begin
      vtx += longint'((wide_t'(w.pos_y) * wr) >>> 20);
      vty -= longint'((wide_t'(w.pos_x) * wr) >>> 20);
      atx += longint'((wide_t'(w.vel_y) * wr) >>> 19)
           + longint'((wide_t'(w.pos_x) * wsq) >>> 56);
      aty += longint'((wide_t'(w.pos_y) * wsq) >>> 56)
           - longint'((wide_t'(w.vel_x) * wr) >>> 19);
    end
    o.fixed_pos_x = 40'(round_clip(wide_t'(c) * wide_t'(w.pos_x)
                                   + wide_t'(s) * wide_t'(w.pos_y), 61, 40));
    o.fixed_pos_y = 40'(round_clip(wide_t'(c) * wide_t'(w.pos_y)
                                   - wide_t'(s) * wide_t'(w.pos_x), 61, 40));
    o.fixed_pos_z = w.pos_z;
    o.fixed_vel_x = 32'(round_clip(wide_t'(c) * wide_t'(vtx) + wide_t'(s) * wide_t'(vty),
                                   77, 32));
    o.fixed_vel_y = 32'(round_clip(wide_t'(c) * wide_t'(vty) - wide_t'(s) * wide_t'(vtx),
                                   77, 32));
    o.fixed_vel_z = w.vel_z;
    o.fixed_acc_x = 32'(round_clip(wide_t'(c) * wide_t'(atx) + wide_t'(s) * wide_t'(aty),
                                   77, 32));
    o.fixed_acc_y = 32'(round_clip(wide_t'(c) * wide_t'(aty) - wide_t'(s) * wide_t'(atx),
                                   77, 32));
    o.fixed_acc_z = w.acc_z;
    return o;
  endfunction

  task automatic report_field(string name, longint got, longint want);
    if (got != want) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, name, got, want);
      errors++;
    end
  endtask

  initial begin
    cordic_gain = gain_start();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      turns_rate = RATE_TURNS_RST;
      rads_rate  = RATE_RADIANS_RST;
      fixed_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RATE_TURNS) turns_rate = cfg_data_i[TURNS_W-1:0];
        else if (cfg_idx_i == REG_RATE_RADIANS) rads_rate = cfg_data_i[RADS_W-1:0];
      end
      if (in_valid_i && !in_stall_i) fixed_q.push_back(predict_fixed(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (fixed_q.size() == 0) begin
          $display("%0t mismatch: unexpected output word", $realtime);
          errors++;
        end else begin
          want = fixed_q.pop_front();
          report_field("fixed_pos_x", out_word_i.fixed_pos_x, want.fixed_pos_x);
          report_field("fixed_pos_y", out_word_i.fixed_pos_y, want.fixed_pos_y);
          report_field("fixed_pos_z", out_word_i.fixed_pos_z, want.fixed_pos_z);
          report_field("fixed_vel_x", out_word_i.fixed_vel_x, want.fixed_vel_x);
          report_field("fixed_vel_y", out_word_i.fixed_vel_y, want.fixed_vel_y);
          report_field("fixed_vel_z", out_word_i.fixed_vel_z, want.fixed_vel_z);
          report_field("fixed_acc_x", out_word_i.fixed_acc_x, want.fixed_acc_x);
          report_field("fixed_acc_y", out_word_i.fixed_acc_y, want.fixed_acc_y);
          report_field("fixed_acc_z", out_word_i.fixed_acc_z, want.fixed_acc_z);
        end
      end
    end
  end

endmodule

// ===== tb/sv/eci_to_ecef_state_rotation_tb.sv =====
// ----------------------------------------------------------------------------
// eci_to_ecef_state_rotation_tb
// Drives directed and random inertial words through the Earth rotation
// transform under several rate settings, with random idling on both sides
// and one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module eci_to_ecef_state_rotation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecisr_pkg::*;

  localparam int LIMIT   = 400000;
  localparam int DRAIN   = 40;
  localparam int PER_SET = 250;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_RATE_TURNS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_took = 1'b0;
  logic                 quiet = 1'b0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;

  always #5 clk_i = ~clk_i;

  eci_to_ecef_state_rotation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  eci_to_ecef_state_rotation_chk chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_word_i  (in_word),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_word_i (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    in_took <= in_valid && !in_stall;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    int hold;
    if (rst_ni && !quiet) begin
      if (cycles > 300 && cycles < 310) hold = 300;
      else if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
      else hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] pick_field(int width, int sel);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case (sel)
      0: v = 0;
      1: v = -(64'sd1 <<< (width - 1));
      2: v = (64'sd1 <<< (width - 1)) - 1;
      default: v = (v <<< (64 - width)) >>> (64 - width + $urandom_range(0, width - 1));
    endcase
    return v;
  endfunction

  function automatic in_word_t make_word(int sel);
    in_word_t w;
    w.time_s = 48'(pick_field(48, sel));
    w.pos_x  = 40'(pick_field(40, sel));
    w.pos_y  = 40'(pick_field(40, sel < 3 ? 3 - sel : sel));
    w.pos_z  = 40'(pick_field(40, sel));
    w.vel_x  = 32'(pick_field(32, sel));
    w.vel_y  = 32'(pick_field(32, sel < 3 ? 3 - sel : sel));
    w.vel_z  = 32'(pick_field(32, sel));
    w.acc_x  = 32'(pick_field(32, sel));
    w.acc_y  = 32'(pick_field(32, sel < 3 ? 3 - sel : sel));
    w.acc_z  = 32'(pick_field(32, sel));
    w.mode   = $urandom_range(0, 1) ? MODE_ROTATE : MODE_TRANSPORT;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(negedge clk_i); while (!in_took);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic random_words(int count);
    in_word_t w;
    for (int n = 0; n < count; n++) begin
      w = make_word($urandom_range(0, 19) < 2 ? $urandom_range(0, 2) : 3);
      send_word(w);
    end
  endtask

  initial begin
    in_word_t w;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int j = 0; j < 20; j++) begin
      w = make_word(j % 4);
      w.mode = j[0] ? MODE_ROTATE : MODE_TRANSPORT;
      if (j >= 16) begin
        w.vel_x = 0;
        w.vel_y = 0;
        w.vel_z = 0;
        w.time_s = -(48'sd1 <<< (j - 4));
      end
      send_word(w);
    end
    random_words(PER_SET);
    settle();
    write_reg(REG_RATE_TURNS, 40'hFF_FFFF_FFFF);
    write_reg(REG_RATE_RADIANS, 40'hFF_FFFF_FFFF);
    random_words(PER_SET);
    settle();
    write_reg(REG_RATE_TURNS, '0);
    write_reg(REG_RATE_RADIANS, '0);
    random_words(PER_SET);
    settle();
    write_reg(REG_RATE_TURNS, CFG_W'({$urandom, $urandom}));
    write_reg(REG_RATE_RADIANS, CFG_W'({$urandom, $urandom}));
    random_words(PER_SET);
    settle();
    write_reg(REG_RATE_TURNS, CFG_W'(RATE_TURNS_RST));
    write_reg(REG_RATE_RADIANS, CFG_W'(RATE_RADIANS_RST));
    quiet <= 1'b1;
    random_words(PER_SET);
    settle();
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
